/* rtl/alp_pkg.sv */
// Shared types and constants for the address lease pool.
`default_nettype none
package alp_pkg;

	localparam int POOL_SIZE_DEF = 64;
	localparam int ADDR_W = 32;
	localparam int TIME_W = 32;
	localparam int DUR_W = 24;
	localparam int CNT_W = 7;
	localparam int IDXREG_W = 1;
	localparam int WDATA_W = 32;

	typedef logic [1:0] op_t;
	localparam op_t OP_DISCOVER = 2'd0;
	localparam op_t OP_REQUEST = 2'd1;
	localparam op_t OP_SWEEP = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_OFFER = 3'd0;
	localparam status_t ST_ACK = 3'd1;
	localparam status_t ST_FULL = 3'd2;
	localparam status_t ST_REFUSED = 3'd3;
	localparam status_t ST_SWEPT = 3'd4;

	typedef logic [IDXREG_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_DURATION = 1'd0;
	localparam reg_idx_t REG_BASE = 1'd1;

	localparam logic [DUR_W-1:0] DURATION_RST = 24'd3600;
	localparam logic [ADDR_W-1:0] BASE_RST = 32'hC0A8_0164;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic valid;
		op_t op;
		logic [TIME_W-1:0] now;
		logic [ADDR_W-1:0] idx;
		logic found;
		logic [CNT_W-1:0] count;
	} token_t;

endpackage
`default_nettype wire

/* rtl/alp_item_if.sv */
// Input item channel of the address lease pool.
`default_nettype none
interface alp_item_if
	import alp_pkg::*;
();
	logic valid;
	logic ready;
	op_t opcode;
	logic [ADDR_W-1:0] requested_address;
	logic [TIME_W-1:0] now;

	modport source (output valid, output opcode, output requested_address, output now,
		input ready);
	modport sink (input valid, input opcode, input requested_address, input now,
		output ready);
endinterface
`default_nettype wire

/* rtl/alp_result_if.sv */
// Result item channel of the address lease pool.
`default_nettype none
interface alp_result_if
	import alp_pkg::*;
();
	logic valid;
	logic ready;
	status_t status;
	logic [ADDR_W-1:0] address;
	logic [CNT_W-1:0] released_count;

	modport source (output valid, output status, output address, output released_count,
		input ready);
	modport sink (input valid, input status, input address, input released_count,
		output ready);
endinterface
`default_nettype wire

/* rtl/alp_lease_cell.sv */
// One lease entry of the pool: in-use flag, start time and the token stage it passes on.
`default_nettype none
module alp_lease_cell
	import alp_pkg::*;
#(
	parameter int INDEX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic [DUR_W-1:0] duration,
	input wire token_t tok_i,
	output token_t tok_o
);

	logic in_use_q;
	logic [TIME_W-1:0] start_q;
	token_t tok_q;
	token_t tok_next;
	logic expired;
	logic claim;
	logic release_now;
	logic [TIME_W:0] limit;

	assign limit = {1'b0, start_q} + {{(TIME_W + 1 - DUR_W){1'b0}}, duration};
	assign expired = {1'b0, tok_i.now} > limit;
	assign claim = tok_i.valid && tok_i.op == OP_DISCOVER && !tok_i.found && !in_use_q;
	assign release_now = tok_i.valid && tok_i.op == OP_SWEEP && in_use_q && expired;

	always_comb begin
		tok_next = tok_i;
		if (claim) begin
			tok_next.found = 1'b1;
			tok_next.idx = ADDR_W'(INDEX);
		end
		if (tok_i.valid && tok_i.op == OP_REQUEST && in_use_q
				&& tok_i.idx == ADDR_W'(INDEX)) begin
			tok_next.found = 1'b1;
		end
		if (release_now && tok_i.count != CNT_MAX) begin
			tok_next.count = tok_i.count + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_next;
			if (claim) begin
				in_use_q <= 1'b1;
			end else if (release_now) begin
				in_use_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && claim) begin
			start_q <= tok_i.now;
		end
	end

	assign tok_o = tok_q;

endmodule
`default_nettype wire

/* rtl/address_lease_pool.sv */
// Top level of the address lease pool: config registers, cell chain and result register.
// An accepted item passes through every lease cell register and then the result register before its result is output.
// Throughput: one item per cycle; each item walks the chain of lease cells one cell a cycle.
// The whole chain stalls while a result waits in the output register and is not taken.
// Reset clears all in-use flags and loads the duration and base address defaults.
// Start times are not reset; an entry's start time is written when a discover claims it.
`default_nettype none
module address_lease_pool
	import alp_pkg::*;
#(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	alp_item_if.sink items,
	alp_result_if.source results,
	input wire logic wr_en,
	input wire reg_idx_t wr_index,
	input wire logic [WDATA_W-1:0] wr_data
);

	logic [DUR_W-1:0] duration_q;
	logic [ADDR_W-1:0] base_q;
	logic adv;
	token_t tok [POOL_SIZE+1];
	token_t last;
	logic res_valid_q;
	status_t status_q;
	logic [ADDR_W-1:0] address_q;
	logic [CNT_W-1:0] count_q;
	status_t status_next;
	logic [ADDR_W-1:0] address_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= DURATION_RST;
			base_q <= BASE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DURATION: duration_q <= wr_data[DUR_W-1:0];
				REG_BASE: base_q <= wr_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv = !res_valid_q || results.ready;
	assign items.ready = adv;

	always_comb begin
		tok[0].valid = items.valid;
		tok[0].op = items.opcode;
		tok[0].now = items.now;
		tok[0].idx = items.requested_address - base_q;
		tok[0].found = 1'b0;
		tok[0].count = '0;
	end

	for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
		alp_lease_cell #(
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.duration(duration_q),
			.tok_i(tok[i]),
			.tok_o(tok[i+1])
		);
	end

	assign last = tok[POOL_SIZE];

	always_comb begin
		status_next = ST_REFUSED;
		address_next = '0;
		case (last.op)
			OP_DISCOVER: begin
				status_next = last.found ? ST_OFFER : ST_FULL;
				address_next = last.found ? base_q + last.idx : '0;
			end
			OP_REQUEST: begin
				status_next = last.found ? ST_ACK : ST_REFUSED;
				address_next = last.found ? base_q + last.idx : '0;
			end
			OP_SWEEP: status_next = ST_SWEPT;
			default: status_next = ST_REFUSED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last.valid) begin
			status_q <= status_next;
			address_q <= address_next;
			count_q <= (last.op == OP_SWEEP) ? last.count : '0;
		end
	end

	assign results.valid = res_valid_q;
	assign results.status = status_q;
	assign results.address = address_q;
	assign results.released_count = count_q;

`ifndef ASSERT_OFF
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> status_q <= ST_SWEPT)
		else $error("result status out of range");
	a_count_only_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q != ST_SWEPT |-> count_q == '0)
		else $error("released count on a non-sweep result");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (status_q == ST_FULL || status_q == ST_REFUSED
			|| status_q == ST_SWEPT) |-> address_q == '0)
		else $error("address set on a result that carries none");
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(last))
		else $error("cell chain moved during a stall");
`endif

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Testbench for address_lease_pool: random and directed lease traffic checked against a local model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import alp_pkg::*;

	localparam op_t OP_UNUSED = 2'd3;

	typedef struct {
		op_t op;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] stamp;
	} lease_req_t;

	typedef struct packed {
		status_t status;
		logic [ADDR_W-1:0] address;
		logic [CNT_W-1:0] released_count;
	} lease_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	reg_idx_t wr_index = REG_DURATION;
	logic [WDATA_W-1:0] wr_data = '0;

	alp_item_if item_ch ();
	alp_result_if result_ch ();

	address_lease_pool uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.results(result_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	bit [POOL_SIZE_DEF-1:0] held = '0;
	logic [TIME_W-1:0] started [POOL_SIZE_DEF];
	logic [DUR_W-1:0] lease_dur = DURATION_RST;
	logic [ADDR_W-1:0] lease_base = BASE_RST;

	lease_req_t pending [$];
	lease_reply_t replies [$];
	lease_req_t next_req;
	lease_reply_t want_reply;
	lease_reply_t got_reply;
	int issued = 0;
	int answered = 0;
	int faults = 0;
	bit calm = 1'b0;
	logic [TIME_W-1:0] wallclock = '0;

	function automatic lease_reply_t serve_item(op_t op, logic [ADDR_W-1:0] addr,
			logic [TIME_W-1:0] stamp);
		lease_reply_t reply;
		logic [ADDR_W-1:0] slot;
		logic [TIME_W:0] limit;
		int freed;
		bit placed;
		reply = '{ST_REFUSED, '0, '0};
		freed = 0;
		placed = 1'b0;
		case (op)
			OP_DISCOVER: begin
				reply.status = ST_FULL;
				for (int i = 0; i < POOL_SIZE_DEF && !placed; i++) begin
					if (!held[i]) begin
						held[i] = 1'b1;
						started[i] = stamp;
						reply.status = ST_OFFER;
						reply.address = lease_base + ADDR_W'(i);
						placed = 1'b1;
					end
				end
			end
			OP_REQUEST: begin
				slot = addr - lease_base;
				if (slot < ADDR_W'(POOL_SIZE_DEF) && held[slot]) begin
					reply.status = ST_ACK;
					reply.address = addr;
				end
			end
			OP_SWEEP: begin
				for (int i = 0; i < POOL_SIZE_DEF; i++) begin
					limit = {1'b0, started[i]} + (TIME_W+1)'(lease_dur);
					if (held[i] && {1'b0, stamp} > limit) begin
						held[i] = 1'b0;
						freed++;
					end
				end
				reply.status = ST_SWEPT;
				reply.released_count = (freed > CNT_MAX) ? CNT_MAX : CNT_W'(freed);
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	initial begin
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_DISCOVER;
		item_ch.requested_address = '0;
		item_ch.now = '0;
		result_ch.ready = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				replies.push_back(serve_item(item_ch.opcode, item_ch.requested_address,
					item_ch.now));
			if (!item_ch.valid || item_ch.ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
					next_req = pending.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.opcode <= next_req.op;
					item_ch.requested_address <= next_req.addr;
					item_ch.now <= next_req.stamp;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got_reply = '{result_ch.status, result_ch.address, result_ch.released_count};
				if (replies.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected result: status %0d address %h count %0d",
							got_reply.status, got_reply.address, got_reply.released_count);
				end else begin
					want_reply = replies.pop_front();
					answered++;
					if (got_reply !== want_reply) begin
						faults++;
						if (faults <= 10)
							$display("mismatch: expected status %0d address %h count %0d, got status %0d address %h count %0d",
								want_reply.status, want_reply.address,
								want_reply.released_count, got_reply.status,
								got_reply.address, got_reply.released_count);
					end
				end
			end
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
		end
	end

	task automatic queue_item(op_t op, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] stamp);
		lease_req_t req;
		req.op = op;
		req.addr = addr;
		req.stamp = stamp;
		pending.push_back(req);
		issued++;
	endtask

	task automatic queue_random(int count, int discover_pct, int step_max);
		op_t op;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] stamp;
		int r;
		int k;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < discover_pct)
				op = OP_DISCOVER;
			else if (r < discover_pct + 12)
				op = OP_SWEEP;
			else if (r < discover_pct + 15)
				op = OP_UNUSED;
			else
				op = OP_REQUEST;
			k = $urandom_range(0, 19);
			if (op != OP_REQUEST || k >= 17)
				addr = $urandom;
			else if (k < 14)
				addr = lease_base + ADDR_W'($urandom_range(0, POOL_SIZE_DEF + 5));
			else
				addr = lease_base - ADDR_W'($urandom_range(1, 4));
			wallclock = wallclock + TIME_W'($urandom_range(0, step_max));
			stamp = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : wallclock;
			queue_item(op, addr, stamp);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [WDATA_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_DURATION)
			lease_dur = data[DUR_W-1:0];
		else
			lease_base = data[ADDR_W-1:0];
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (answered != issued);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		queue_item(OP_DISCOVER, $urandom, 32'd0);
		queue_item(OP_DISCOVER, $urandom, 32'd100);
		queue_item(OP_REQUEST, lease_base, $urandom);
		queue_item(OP_REQUEST, lease_base + 1, $urandom);
		queue_item(OP_REQUEST, lease_base + 2, $urandom);
		queue_item(OP_REQUEST, lease_base + POOL_SIZE_DEF, $urandom);
		queue_item(OP_REQUEST, lease_base - 1, $urandom);
		queue_item(OP_REQUEST, 32'h0000_0000, 32'h0000_0000);
		queue_item(OP_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(OP_UNUSED, $urandom, $urandom);
		queue_item(OP_UNUSED, lease_base, 32'hFFFF_FFFF);
		queue_item(OP_SWEEP, $urandom, 32'd3600);
		queue_item(OP_SWEEP, $urandom, 32'd3601);
		queue_item(OP_REQUEST, lease_base, $urandom);
		queue_item(OP_DISCOVER, $urandom, 32'hFFFF_FFFF);
		queue_item(OP_SWEEP, $urandom, 32'hFFFF_FFFF);
		queue_item(OP_REQUEST, lease_base, 32'd0);
		queue_item(OP_REQUEST, lease_base + 1, 32'd0);
		queue_item(OP_SWEEP, $urandom, 32'd0);
		wait_idle();

		write_reg(REG_DURATION, {8'hA5, 24'd30});
		write_reg(REG_BASE, $urandom);
		queue_random(125, 45, 3);
		wait_idle();

		write_reg(REG_DURATION, 32'd1);
		write_reg(REG_BASE, 32'h0000_0000);
		queue_random(125, 45, 3);
		wait_idle();

		write_reg(REG_DURATION, 32'h00FF_FFFF);
		write_reg(REG_BASE, 32'hFFFF_FFFF);
		wallclock = 32'hFFFF_FF00;
		queue_random(125, 70, 2);
		wait_idle();

		write_reg(REG_DURATION, 32'hFF00_0000);
		write_reg(REG_BASE, 32'hFFFF_FFE0);
		queue_random(125, 40, 2);
		wait_idle();

		calm = 1'b1;
		write_reg(REG_DURATION, 32'h5A00_0040);
		write_reg(REG_BASE, $urandom);
		queue_random(125, 45, 4);
		wait_idle();
		calm = 1'b0;

		write_reg(REG_DURATION, {8'($urandom), 24'($urandom_range(2, 200))});
		write_reg(REG_BASE, $urandom);
		queue_random(125, 45, 4);
		wait_idle();

		repeat (POOL_SIZE_DEF + 8) @(negedge clk);
		if (faults == 0 && replies.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/alp_pkg.sv
rtl/alp_item_if.sv
rtl/alp_result_if.sv
rtl/alp_lease_cell.sv
rtl/address_lease_pool.sv
sim/testbench.sv
